@@ rtl/ard_pkg.sv @@
// Shared types and constants for the account record decoder.
// No dependencies; the controller, datapath, top level and checker import this package.
package ard_pkg;

   localparam int HASH_BYTES    = 32;
   localparam int BALANCE_BYTES = 32;

   localparam logic [6:0] COUNT_MAX     = 7'd127;
   localparam logic [3:0] MAX_NONCE_LEN = 4'd8;
   localparam logic [3:0] LAST_IDX      = 4'd8;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_TOO_SHORT  = 3'd1;
   localparam logic [2:0] STATUS_BAD_NONCE  = 3'd2;
   localparam logic [2:0] STATUS_BAD_BAL    = 3'd3;
   localparam logic [2:0] STATUS_MISMATCH   = 3'd4;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_BALANCE = 2'd1;
   localparam logic [1:0] KIND_HASH    = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       check;
      logic       clear;
      logic [3:0] emit_idx;
   } ard_cmd_type;

   typedef struct packed {
      logic failed;
   } ard_stat_type;

endpackage

@@ rtl/ard_if.sv @@
// Valid/ready channel interfaces for the record byte input and the result output.
// Depends on nothing but the port widths of the decoder.
interface ard_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ard_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  word_index;
   logic [63:0] value;
   logic [2:0]  status;
   logic        code_present;
   logic        last_result;

   modport source (output valid, output kind, output word_index, output value,
      output status, output code_present, output last_result, input ready);
   modport sink (input valid, input kind, input word_index, input value,
      input status, input code_present, input last_result, output ready);
endinterface

@@ rtl/ard_ctrl.sv @@
// Controller for the account record decoder: receive, check and emit phases.
// Depends on ard_pkg for the command and status structs.
module ard_ctrl
   import ard_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ard_stat_type stat,
   output ard_cmd_type  cmd
);

   localparam logic [1:0] ST_RECV  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] idx_ff, idx_in;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.check   = 1'b0;
      cmd.clear   = 1'b0;
      cmd.emit_idx = idx_ff;
      case (state_ff)
         ST_RECV: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            idx_in    = 4'd0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               // A failed record ends after its single status beat.
               if (stat.failed || idx_ff == LAST_IDX) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_RECV;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RECV;
         idx_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

@@ rtl/ard_dp.sv @@
// Datapath for the account record decoder: field registers, byte placement,
// record check and result selection. Depends on ard_pkg.
module ard_dp
   import ard_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ard_cmd_type  cmd,
   input  logic [7:0]   data_byte,
   output ard_stat_type stat,
   output logic [1:0]   kind,
   output logic [1:0]   word_index,
   output logic [63:0]  value,
   output logic [2:0]   status,
   output logic         code_present,
   output logic         last_result
);

   logic [6:0]   byte_count_ff, byte_count_in;
   logic [7:0]   flag_bits_ff, flag_bits_in;
   logic [7:0]   balance_length_ff, balance_length_in;
   logic [63:0]  nonce_ff, nonce_in;
   logic [255:0] balance_ff, balance_in;
   logic [255:0] hash_ff, hash_in;
   logic [2:0]   status_ff, status_in;

   logic       code;
   logic [3:0] nlen;
   logic [8:0] off, rel, hrel, bal_pos, expected;
   logic       in_body, in_nonce, in_bal, bal_ok, in_hash;
   logic [4:0] bal_byte, hash_byte;
   logic [1:0] word_sel;

   assign code = flag_bits_ff[0];
   assign nlen = flag_bits_ff[4:1];

   // Locate the incoming byte within nonce, balance or hash.
   always_comb begin
      in_body   = byte_count_ff >= 7'd2 && byte_count_ff < COUNT_MAX;
      off       = {2'b00, byte_count_ff} - 9'd2;
      in_nonce  = off < {5'd0, nlen};
      rel       = off - {5'd0, nlen};
      in_bal    = rel < {1'b0, balance_length_ff};
      bal_ok    = balance_length_ff <= 8'(BALANCE_BYTES);
      bal_pos   = 9'd32 - {1'b0, balance_length_ff} + rel;
      bal_byte  = bal_pos[4:0];
      hrel      = rel - {1'b0, balance_length_ff};
      in_hash   = code && hrel < 9'(HASH_BYTES);
      hash_byte = hrel[4:0];
   end

   always_comb begin
      byte_count_in     = byte_count_ff;
      flag_bits_in      = flag_bits_ff;
      balance_length_in = balance_length_ff;
      nonce_in          = nonce_ff;
      balance_in        = balance_ff;
      hash_in           = hash_ff;
      status_in         = status_ff;
      if (cmd.capture) begin
         if (byte_count_ff < COUNT_MAX) begin
            byte_count_in = byte_count_ff + 7'd1;
         end
         if (byte_count_ff == 7'd0) begin
            flag_bits_in = data_byte;
         end else if (byte_count_ff == 7'd1) begin
            balance_length_in = data_byte;
         end else if (in_body) begin
            if (in_nonce) begin
               nonce_in = {nonce_ff[55:0], data_byte};
            end else if (in_bal) begin
               if (bal_ok) begin
                  for (int i = 0; i < 32; i++) begin
                     if (bal_byte == 5'(i)) begin
                        balance_in[255 - 8 * i -: 8] = balance_ff[255 - 8 * i -: 8]
                           | data_byte;
                     end
                  end
               end
            end else if (in_hash) begin
               for (int i = 0; i < 32; i++) begin
                  if (hash_byte == 5'(i)) begin
                     hash_in[255 - 8 * i -: 8] = hash_ff[255 - 8 * i -: 8] | data_byte;
                  end
               end
            end
         end
      end
      if (cmd.check) begin
         if (byte_count_ff < 7'd2) begin
            status_in = STATUS_TOO_SHORT;
         end else if (nlen > MAX_NONCE_LEN) begin
            status_in = STATUS_BAD_NONCE;
         end else if (balance_length_ff > 8'(BALANCE_BYTES)) begin
            status_in = STATUS_BAD_BAL;
         end else if ({2'b00, byte_count_ff} != expected) begin
            status_in = STATUS_MISMATCH;
         end else begin
            status_in = STATUS_OK;
         end
      end
      if (cmd.clear) begin
         byte_count_in     = 7'd0;
         flag_bits_in      = 8'd0;
         balance_length_in = 8'd0;
         nonce_in          = 64'd0;
         balance_in        = 256'd0;
         hash_in           = 256'd0;
      end
   end

   assign expected = 9'd2 + {5'd0, nlen} + {1'b0, balance_length_ff}
      + (code ? 9'(HASH_BYTES) : 9'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff     <= 7'd0;
         flag_bits_ff      <= 8'd0;
         balance_length_ff <= 8'd0;
         nonce_ff          <= 64'd0;
         balance_ff        <= 256'd0;
         hash_ff           <= 256'd0;
         status_ff         <= STATUS_OK;
      end else begin
         byte_count_ff     <= byte_count_in;
         flag_bits_ff      <= flag_bits_in;
         balance_length_ff <= balance_length_in;
         nonce_ff          <= nonce_in;
         balance_ff        <= balance_in;
         hash_ff           <= hash_in;
         status_ff         <= status_in;
      end
   end

   assign stat.failed = status_ff != STATUS_OK;

   // Beat 0 is the header, beats 1 to 4 the balance words, 5 to 8 the hash words.
   always_comb begin
      word_sel = 2'd0;
      if (stat.failed) begin
         kind         = KIND_HEADER;
         word_index   = 2'd0;
         value        = 64'd0;
         code_present = 1'b0;
         last_result  = 1'b1;
      end else begin
         code_present = code;
         last_result  = cmd.emit_idx == LAST_IDX;
         if (cmd.emit_idx == 4'd0) begin
            kind       = KIND_HEADER;
            word_index = 2'd0;
            value      = nonce_ff;
         end else if (cmd.emit_idx < 4'd5) begin
            word_sel   = 2'(cmd.emit_idx - 4'd1);
            kind       = KIND_BALANCE;
            word_index = word_sel;
            value      = balance_ff[255 - 64 * word_sel -: 64];
         end else begin
            word_sel   = 2'(cmd.emit_idx - 4'd5);
            kind       = KIND_HASH;
            word_index = word_sel;
            value      = hash_ff[255 - 64 * word_sel -: 64];
         end
      end
   end

   assign status = status_ff;

endmodule

@@ rtl/account_record_decoder.sv @@
// Top level of the account record decoder; joins controller and datapath.
// Depends on ard_pkg, ard_if, ard_ctrl and ard_dp.

// The decoder takes one record byte per cycle on req_chan while it is
// receiving. Once the beat marked last_byte is taken, req_chan.ready drops
// through the check state and then the results: a valid record gives nine
// beats (nonce header, four balance words, four hash words), a bad one a
// single status beat, each beat held until rsp_chan.ready is high. The first
// byte of the next record is taken the cycle after the final result beat.
// The result beats come from the controller, which steps the result index.
module account_record_decoder
   import ard_pkg::*;
(
   input logic      clock,
   input logic      reset,
   ard_req_if.sink  req_chan,
   ard_rsp_if.source rsp_chan
);

   ard_cmd_type  cmd;
   ard_stat_type stat;
   logic         req_ready;
   logic         rsp_valid;

   ard_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_byte),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ard_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .data_byte    (req_chan.data_byte),
      .stat         (stat),
      .kind         (rsp_chan.kind),
      .word_index   (rsp_chan.word_index),
      .value        (rsp_chan.value),
      .status       (rsp_chan.status),
      .code_present (rsp_chan.code_present),
      .last_result  (rsp_chan.last_result)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

@@ rtl/ard_checker.sv @@
// Port-level checks for the account record decoder, bound to the top level.
// Depends on ard_pkg for status and kind codes.
module ard_checker
   import ard_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  kind,
   input logic [63:0] value,
   input logic [2:0]  status,
   input logic        last_result
);

   // Input and output phases never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is offered");

   a_last_stops_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("input taken right after the last byte");

   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != STATUS_OK |-> last_result && kind == KIND_HEADER
         && value == 64'd0)
      else $error("failure beat is malformed");

   a_end_of_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && last_result |=> !rsp_valid)
      else $error("result offered after the final beat");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(value) && $stable(kind))
      else $error("stalled result changed");

endmodule

bind account_record_decoder ard_checker u_ard_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_last    (req_chan.last_byte),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .kind        (rsp_chan.kind),
   .value       (rsp_chan.value),
   .status      (rsp_chan.status),
   .last_result (rsp_chan.last_result)
);
